### sv/supercap_energy_state_step_defines.svh
// Assertion macros shared by the supercapacitor step block.
`ifndef SUPERCAP_ENERGY_STATE_STEP_DEFINES_SVH
`define SUPERCAP_ENERGY_STATE_STEP_DEFINES_SVH
`ifndef SYNTH
`define SESS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define SESS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define SESS_ASSERT(lbl, prop)
`define SESS_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

### sv/sess_pkg.sv
// Types and constants shared by the supercapacitor step block.
`timescale 1ns / 1ps
`default_nettype none
package sess_pkg;
  localparam int DVD_W  = 96;
  localparam int DSR_W  = 48;
  localparam int STEP_W = 7;
  localparam int RAD_W  = 48;
  localparam int ROOT_W = 24;

  localparam logic [2:0] REG_CAP   = 3'd0;
  localparam logic [2:0] REG_RES   = 3'd1;
  localparam logic [2:0] REG_VMIN  = 3'd2;
  localparam logic [2:0] REG_VMAX  = 3'd3;
  localparam logic [2:0] REG_PMAX  = 3'd4;
  localparam logic [2:0] REG_VSTART = 3'd5;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_LOW  = 2'd1;
  localparam logic [1:0] STATUS_HIGH = 2'd2;

  localparam logic FUNC_RESTART = 1'b1;

  localparam logic [23:0] ONES24 = 24'hFFFFFF;
  localparam logic [31:0] ONES32 = 32'hFFFFFFFF;
  localparam logic [15:0] ONES16 = 16'hFFFF;
  localparam logic [49:0] QCAP   = 50'h2000000000000;
  localparam logic [23:0] VOLT_ONE = 24'd65536;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [DVD_W-1:0]  dividend;
    logic [DSR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic             start;
    logic [RAD_W-1:0] radicand;
  } sq_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [ROOT_W-1:0] root;
  } sq_rsp_t;
endpackage
`default_nettype wire

### sv/sess_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "supercap_energy_state_step_defines.svh"
module sess_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sess_pkg::div_req_t req,
  output sess_pkg::div_rsp_t      rsp
);
  import sess_pkg::*;

  logic              busy_r, done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [DVD_W-1:0]  dvd_r, quot_r;
  logic [DSR_W-1:0]  dsr_r, rem_r;
  logic [DSR_W:0]    rem_sh, diff;
  logic              ge;

  // The dividend is left aligned; its top bits feed the partial remainder.
  assign rem_sh = {rem_r, dvd_r[DVD_W-1]};
  assign diff   = rem_sh - {1'b0, dsr_r};
  assign ge     = rem_sh >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
        dvd_r  <= req.dividend;
        dsr_r  <= req.divisor;
        rem_r  <= '0;
        quot_r <= '0;
      end else if (busy_r) begin
        rem_r  <= ge ? diff[DSR_W-1:0] : rem_sh[DSR_W-1:0];
        quot_r <= {quot_r[DVD_W-2:0], ge};
        dvd_r  <= {dvd_r[DVD_W-2:0], 1'b0};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

  `SESS_ASSERT_NEXT(a_div_start_busy, req.start && req.steps != '0, busy_r)
  `SESS_ASSERT(a_div_done_idle, done_r |-> !busy_r)
endmodule
`default_nettype wire

### sv/sess_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "supercap_energy_state_step_defines.svh"
module sess_sqrt (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire sess_pkg::sq_req_t req,
  output sess_pkg::sq_rsp_t      rsp
);
  import sess_pkg::*;

  logic              busy_r, done_r;
  logic [4:0]        cnt_r;
  logic [RAD_W-1:0]  rad_r, keep_r;
  logic [ROOT_W:0]   rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [ROOT_W+2:0] rem_sh, trial, diff;
  logic              ge;

  assign rem_sh = {rem_r, rad_r[RAD_W-1:RAD_W-2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign diff   = rem_sh - trial;
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(ROOT_W);
        rad_r  <= req.radicand;
        keep_r <= req.radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rem_r  <= ge ? diff[ROOT_W:0] : rem_sh[ROOT_W:0];
        root_r <= {root_r[ROOT_W-2:0], ge};
        rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.root = root_r;

  // The root must be the floor of the true square root.
  `SESS_ASSERT(a_sqrt_floor, done_r |-> (({26'b0, root_r} * {26'b0, root_r}) <= {2'b0, keep_r} && (({25'b0, root_r} + 50'd1) * ({25'b0, root_r} + 50'd1)) > {2'b0, keep_r}))
endmodule
`default_nettype wire

### sv/supercap_energy_state_step.sv
// Top level of the fixed-point supercapacitor energy step block.
`timescale 1ns / 1ps
`default_nettype none
`include "supercap_energy_state_step_defines.svh"
// Each input word is either a time step (tuser low) or a restart (tuser high).
// A time step moves |I|*V*dt into or out of the stored energy, takes the new
// open circuit voltage as a floored square root, and checks it against the
// voltage window; a restart clears consumption and loads the start voltage.
// Every word yields one result word with open and port voltage, maximum
// output current, charge fraction, consumption, suggested next step and
// status. Words are handled one at a time, with the single bit-serial
// divider and the square root in use for each: the divider runs 89 steps
// for the energy quotient and 40 or 48 steps for each of the three output
// ratios, eight fewer for the current ratio with a nonzero series
// resistance; the square root runs 24 steps. A restart skips the energy
// quotient and the square root.
// A finished result waits in the output register, so the next word is
// taken while it is still pending. The user must write configuration only
// while the block is idle; the block itself does not enforce it.
module supercap_energy_state_step (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [31:0]  cfg_wdata,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // tdata fields from bit 0: current[31:0], time_elapsed[63:32], precision[71:64]
  input  wire logic [71:0]  in_tdata,
  // tuser fields from bit 0: func[0]
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // tdata fields from bit 0: open_voltage[23:0], port_voltage[47:24],
  // max_out_current[79:48], charge_fraction[95:80], consumption[143:96],
  // next_step[175:144]
  output logic [175:0]      out_tdata,
  // tuser fields from bit 0: status[1:0]
  output logic [1:0]        out_tuser
);
  import sess_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL1  = 4'd1;
  localparam logic [3:0] ST_MUL2  = 4'd2;
  localparam logic [3:0] ST_MUL3  = 4'd3;
  localparam logic [3:0] ST_DIVE  = 4'd4;
  localparam logic [3:0] ST_DIVEW = 4'd5;
  localparam logic [3:0] ST_SQ    = 4'd6;
  localparam logic [3:0] ST_SQW   = 4'd7;
  localparam logic [3:0] ST_PORT  = 4'd8;
  localparam logic [3:0] ST_DIVC  = 4'd9;
  localparam logic [3:0] ST_DIVCW = 4'd10;
  localparam logic [3:0] ST_DIVF  = 4'd11;
  localparam logic [3:0] ST_DIVFW = 4'd12;
  localparam logic [3:0] ST_DIVN  = 4'd13;
  localparam logic [3:0] ST_DIVNW = 4'd14;
  localparam logic [3:0] ST_OUT   = 4'd15;

  localparam logic signed [57:0] E_HI = 58'sh00007FFFFFFFFFFF;
  localparam logic signed [57:0] E_LO = -58'sh0000800000000000;

  // Configuration registers.
  logic [31:0] cap_r, pmax_r;
  logic [23:0] res_r, vmin_r, vmax_r, vstart_r;

  // State of the cell.
  logic [23:0] cell_v_r;
  logic [47:0] energy_r;

  // Working registers for one word.
  logic [3:0]  state_r;
  logic        neg_r;
  logic [31:0] mag_r, dt_r;
  logic [11:0] k_r;
  logic [55:0] p_r, thi_r, hi_r, pr_r;
  logic [63:0] tlo_r;
  logic [31:0] lo_r;
  logic [47:0] vsq_r, nsq_r;
  logic [43:0] den_r;
  logic [1:0]  status_r;
  logic [23:0] port_r;
  logic [31:0] maxcur_r, next_r;
  logic [15:0] frac_r;

  logic        out_tvalid_r;
  logic [175:0] out_tdata_r;
  logic [1:0]  out_tuser_r;

  div_req_t div_req;
  div_rsp_t div_rsp;
  sq_req_t  sq_req;
  sq_rsp_t  sq_rsp;

  logic [31:0] cap_eff;
  logic [31:0] cur_in, mag_in;
  logic        accept;
  logic [49:0] x_cap;
  logic [50:0] nsq_sum;
  logic [47:0] nsq_val;
  logic signed [57:0] e_sum;
  logic [39:0] ir_drop;
  logic [24:0] port_sum;
  logic [23:0] port_val;
  logic [31:0] maxcur_val;

  sess_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));
  sess_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .req(sq_req), .rsp(sq_rsp));

  // A zero capacitance acts as the smallest representable one.
  assign cap_eff = (cap_r == '0) ? 32'd1 : cap_r;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign cur_in    = in_tdata[31:0];
  assign mag_in    = cur_in[31] ? (32'd0 - cur_in) : cur_in;

  // Divider and square-root requests are issued from their start states.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.steps    = STEP_W'(48);
    div_req.dividend = '0;
    div_req.divisor  = '0;
    sq_req.start     = (state_r == ST_SQ);
    sq_req.radicand  = nsq_r;
    unique case (state_r)
      ST_DIVE: begin
        // The moved energy {hi, lo} with eight zero bits appended, over the capacitance.
        div_req.start    = 1'b1;
        div_req.steps    = STEP_W'(89);
        div_req.dividend = {hi_r, lo_r, 8'b0};
        div_req.divisor  = {16'b0, cap_eff};
      end
      ST_DIVC: begin
        div_req.start = 1'b1;
        if (res_r == '0) begin
          div_req.steps    = STEP_W'(48);
          div_req.dividend = {pmax_r, 16'b0, 48'b0};
          div_req.divisor  = {24'b0, cell_v_r};
        end else begin
          div_req.steps    = STEP_W'(40);
          div_req.dividend = {cell_v_r, 16'b0, 56'b0};
          div_req.divisor  = {24'b0, res_r};
        end
      end
      ST_DIVF: begin
        div_req.start    = 1'b1;
        div_req.steps    = STEP_W'(40);
        div_req.dividend = {cell_v_r, 16'b0, 56'b0};
        div_req.divisor  = {24'b0, vmax_r};
      end
      ST_DIVN: begin
        div_req.start    = 1'b1;
        div_req.steps    = STEP_W'(48);
        div_req.dividend = {cap_eff, 16'b0, 48'b0};
        div_req.divisor  = {4'b0, den_r};
      end
      default: begin
      end
    endcase
  end

  // The energy quotient is capped; the new squared voltage saturates at 48 bits and at zero.
  always_comb begin
    x_cap = (div_rsp.quot > {46'b0, QCAP}) ? QCAP : div_rsp.quot[49:0];
    nsq_sum = {3'b0, vsq_r} + {1'b0, x_cap};
    if (neg_r) begin
      nsq_val = ({2'b0, vsq_r} <= x_cap) ? 48'd0 : (vsq_r - x_cap[47:0]);
    end else begin
      nsq_val = (nsq_sum[50:48] != '0) ? 48'hFFFFFFFFFFFF : nsq_sum[47:0];
    end
  end

  // Charging lowers the energy drawn, discharging raises it.
  assign e_sum = $signed({{10{energy_r[47]}}, energy_r}) +
                 (neg_r ? $signed({2'b0, hi_r}) : -$signed({2'b0, hi_r}));

  // Port voltage is V plus or minus the truncated I*R drop, clamped to the 24-bit range.
  assign ir_drop  = pr_r[55:16];
  assign port_sum = {1'b0, cell_v_r} + ir_drop[24:0];
  always_comb begin
    if (neg_r) begin
      port_val = (ir_drop >= {16'b0, cell_v_r}) ? 24'd0 : (cell_v_r - ir_drop[23:0]);
    end else if (ir_drop[39:24] != '0 || port_sum[24]) begin
      port_val = ONES24;
    end else begin
      port_val = port_sum[23:0];
    end
  end

  always_comb begin
    if (cell_v_r < vmin_r) begin
      maxcur_val = '0;
    end else if (cell_v_r == '0) begin
      maxcur_val = ONES32;
    end else if (div_rsp.quot[95:32] != '0) begin
      maxcur_val = ONES32;
    end else begin
      maxcur_val = div_rsp.quot[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      cap_r        <= 32'd65536;
      res_r        <= '0;
      vmin_r       <= '0;
      vmax_r       <= ONES24;
      pmax_r       <= 32'd6553600;
      vstart_r     <= VOLT_ONE;
      cell_v_r     <= VOLT_ONE;
      energy_r     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_CAP:    cap_r    <= cfg_wdata;
          REG_RES:    res_r    <= cfg_wdata[23:0];
          REG_VMIN:   vmin_r   <= cfg_wdata[23:0];
          REG_VMAX:   vmax_r   <= cfg_wdata[23:0];
          REG_PMAX:   pmax_r   <= cfg_wdata;
          REG_VSTART: vstart_r <= cfg_wdata[23:0];
          default: begin
          end
        endcase
      end

      // In the output state the sequencer itself decides the next valid.
      if (out_tvalid_r && out_tready && state_r != ST_OUT) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            neg_r    <= cur_in[31];
            mag_r    <= mag_in;
            dt_r     <= in_tdata[63:32];
            k_r      <= 12'(({4'b0, in_tdata[71:64]} + 12'd1) * 12'd10);
            status_r <= STATUS_OK;
            if (in_tuser == FUNC_RESTART) begin
              cell_v_r <= vstart_r;
              energy_r <= '0;
              state_r  <= ST_PORT;
            end else begin
              state_r  <= ST_MUL1;
            end
          end
        end
        ST_MUL1: begin
          p_r     <= {24'b0, mag_r} * {32'b0, cell_v_r};
          vsq_r   <= {24'b0, cell_v_r} * {24'b0, cell_v_r};
          state_r <= ST_MUL2;
        end
        ST_MUL2: begin
          tlo_r   <= {32'b0, p_r[31:0]} * {32'b0, dt_r};
          thi_r   <= {32'b0, p_r[55:32]} * {24'b0, dt_r};
          state_r <= ST_MUL3;
        end
        ST_MUL3: begin
          hi_r    <= thi_r + {24'b0, tlo_r[63:32]};
          lo_r    <= tlo_r[31:0];
          state_r <= ST_DIVE;
        end
        ST_DIVE: state_r <= ST_DIVEW;
        ST_DIVEW: begin
          if (div_rsp.done) begin
            nsq_r   <= nsq_val;
            state_r <= ST_SQ;
          end
        end
        ST_SQ: state_r <= ST_SQW;
        ST_SQW: begin
          if (sq_rsp.done) begin
            cell_v_r <= sq_rsp.root;
            if (sq_rsp.root < vmin_r) begin
              status_r <= STATUS_LOW;
            end else if (sq_rsp.root > vmax_r) begin
              status_r <= STATUS_HIGH;
            end else if (e_sum > E_HI) begin
              energy_r <= E_HI[47:0];
            end else if (e_sum < E_LO) begin
              energy_r <= E_LO[47:0];
            end else begin
              energy_r <= e_sum[47:0];
            end
            state_r <= ST_PORT;
          end
        end
        ST_PORT: begin
          pr_r    <= {24'b0, mag_r} * {32'b0, res_r};
          den_r   <= {32'b0, k_r} * {12'b0, mag_r};
          state_r <= ST_DIVC;
        end
        ST_DIVC: begin
          port_r  <= port_val;
          state_r <= ST_DIVCW;
        end
        ST_DIVCW: begin
          if (div_rsp.done) begin
            maxcur_r <= maxcur_val;
            state_r  <= ST_DIVF;
          end
        end
        ST_DIVF: state_r <= ST_DIVFW;
        ST_DIVFW: begin
          if (div_rsp.done) begin
            if (vmax_r == ONES24) begin
              frac_r <= '0;
            end else if (vmax_r == '0 || div_rsp.quot[95:16] != '0) begin
              frac_r <= ONES16;
            end else begin
              frac_r <= div_rsp.quot[15:0];
            end
            state_r <= ST_DIVN;
          end
        end
        ST_DIVN: state_r <= ST_DIVNW;
        ST_DIVNW: begin
          if (div_rsp.done) begin
            if (mag_r == '0 || div_rsp.quot[95:32] != '0) begin
              next_r <= ONES32;
            end else begin
              next_r <= div_rsp.quot[31:0];
            end
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          // Hand the word to the output register once it is free.
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {next_r, energy_r, frac_r, maxcur_r, port_r, cell_v_r};
            out_tuser_r  <= status_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  `SESS_ASSERT(a_div_free, div_req.start |-> !div_rsp.busy)
  `SESS_ASSERT(a_sqrt_free, sq_req.start |-> !sq_rsp.busy)
  `SESS_ASSERT(a_out_from_seq, $rose(out_tvalid_r) |-> $past(state_r) == ST_OUT)
endmodule
`default_nettype wire
